FILE: rtl/core/route_list_engine_defines.svh
// ---------------------------------------------------------------------------
// route_list_engine_defines
// Assertion macros shared by the route list engine RTL.
// ---------------------------------------------------------------------------
`ifndef ROUTE_LIST_ENGINE_DEFINES_SVH
`define ROUTE_LIST_ENGINE_DEFINES_SVH

// Implication checked on every rising clock edge outside reset
`define RLE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define RLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/rle_pkg.sv
// ---------------------------------------------------------------------------
// rle_pkg
// Shared constants and command codes of the route list engine.
// ---------------------------------------------------------------------------
`default_nettype none
package rle_pkg;
    localparam int DEPTH_DEF       = 64;
    localparam int VALUE_WIDTH_DEF = 16;
    localparam int CMD_W           = 4;
    localparam int IDX_W           = 6;
    localparam int CNT_W           = 7;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 16;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEPOT    = 1'd1;

    localparam logic [CMD_W-1:0] CMD_CLEAR   = 4'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND  = 4'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE  = 4'd2;
    localparam logic [CMD_W-1:0] CMD_REVERSE = 4'd3;
    localparam logic [CMD_W-1:0] CMD_REV_DEP = 4'd4;
    localparam logic [CMD_W-1:0] CMD_SWAP    = 4'd5;
    localparam logic [CMD_W-1:0] CMD_MEMBER  = 4'd6;
    localparam logic [CMD_W-1:0] CMD_NEXT    = 4'd7;
    localparam logic [CMD_W-1:0] CMD_READ    = 4'd8;
endpackage
`default_nettype wire

FILE: rtl/core/route_list_engine.sv
// ---------------------------------------------------------------------------
// route_list_engine
// Bounded node list with clear, append, remove, 2-opt reversal, swap, read and search.
// ---------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy then stays high
// until done pulses for one cycle with the result. The receiver cannot stall.
// The store is one memory with one registered read port and one write port,
// walked by a small sequencer. Clear, append and unused codes go straight to
// done; read and swap use the read port and then finish; remove and search
// walk the list entry by entry (a member hit stops early); the reversals read
// each pair and write it back, stepping past depot entries in the depot variant
// (one read per cycle, a pair written back).
`default_nettype none
`include "route_list_engine_defines.svh"
module route_list_engine #(
    parameter int VALUE_WIDTH = rle_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    output logic                               done,
    input  wire logic                          cfg_we,
    input  wire logic [rle_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rle_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic [rle_pkg::CMD_W-1:0]     command,
    input  wire logic [VALUE_WIDTH-1:0]        value,
    input  wire logic [rle_pkg::IDX_W-1:0]     first_index,
    input  wire logic [rle_pkg::IDX_W-1:0]     second_index,
    output logic [VALUE_WIDTH-1:0]             result_value,
    output logic                               found,
    output logic [rle_pkg::CNT_W-1:0]          item_count,
    output logic                               is_full,
    output logic                               list_empty,
    output logic                               overflow
);
    localparam int DEPTH = rle_pkg::DEPTH_DEF;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = rle_pkg::CNT_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SCAN = 4'd1;  // remove/member/next: read i
    localparam logic [3:0] S_SCHK = 4'd2;  // check data of i
    localparam logic [3:0] S_RA   = 4'd3;  // reverse/swap: read a
    localparam logic [3:0] S_RB   = 4'd4;  // read b, latch a
    localparam logic [3:0] S_RC   = 4'd5;  // latch b, decide
    localparam logic [3:0] S_WB   = 4'd6;  // write second of pair
    localparam logic [3:0] S_RD   = 4'd7;  // single read wait
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0]             state_reg, state_next;
    logic [VALUE_WIDTH-1:0] mem [DEPTH];
    logic [VALUE_WIDTH-1:0] rdata_reg;
    logic [AW-1:0]          raddr;
    logic                   we;
    logic [AW-1:0]          waddr;
    logic [VALUE_WIDTH-1:0] wdata;

    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          cap_reg;
    logic [VALUE_WIDTH-1:0] depot_reg;
    logic [rle_pkg::CMD_W-1:0] cmd_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [CW-1:0]          a_reg, a_next, b_reg, b_next, k_reg, k_next;
    logic [VALUE_WIDTH-1:0] da_reg, da_next;
    logic [VALUE_WIDTH-1:0] res_reg, res_next;
    logic                   fnd_reg, fnd_next, ovf_reg, ovf_next;
    logic                   done_reg, done_next;
    logic [CW-1:0]          lim;
    logic [CW:0]            i1w, i2w;

    // Memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign lim = (32'(cap_reg) < DEPTH) ? cap_reg : CW'(DEPTH);
    assign i1w = (CW+1)'(first_index);
    assign i2w = (CW+1)'(second_index);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CW'(64);
            depot_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rle_pkg::REG_CAPACITY: cap_reg <= cfg_data[CW-1:0];
                rle_pkg::REG_DEPOT: depot_reg <= VALUE_WIDTH'(cfg_data);
                default: ;
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        a_next = a_reg; b_next = b_reg; k_next = k_reg;
        da_next = da_reg;
        res_next = res_reg; fnd_next = fnd_reg; ovf_next = ovf_reg;
        done_next = 1'b0;
        we = 1'b0; waddr = '0; wdata = '0;
        raddr = a_reg[AW-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    res_next = '0; fnd_next = 1'b0; ovf_next = 1'b0;
                    a_next = CW'(first_index); b_next = CW'(second_index);
                    k_next = '0;
                    state_next = S_DONE;
                    case (command)
                        rle_pkg::CMD_CLEAR: count_next = '0;
                        rle_pkg::CMD_APPEND:
                        begin
                            if (count_reg >= lim) ovf_next = 1'b1;
                            else
                            begin
                                we = 1'b1; waddr = count_reg[AW-1:0]; wdata = value;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        rle_pkg::CMD_REMOVE, rle_pkg::CMD_MEMBER, rle_pkg::CMD_NEXT:
                        begin
                            a_next = '0;
                            state_next = S_SCAN;
                        end
                        rle_pkg::CMD_REVERSE, rle_pkg::CMD_REV_DEP, rle_pkg::CMD_SWAP:
                        begin
                            if (command == rle_pkg::CMD_SWAP)
                            begin
                                if (i1w < (CW+1)'(count_reg) && i2w < (CW+1)'(count_reg))
                                    state_next = S_RA;
                            end
                            else if (i1w <= i2w && i2w < (CW+1)'(count_reg))
                                state_next = S_RA;
                        end
                        rle_pkg::CMD_READ:
                        begin
                            if (i1w < (CW+1)'(count_reg))
                            begin
                                raddr = first_index[AW-1:0];
                                state_next = S_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RD:
            begin
                res_next = rdata_reg;
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                if (a_reg >= count_reg)
                begin
                    if (cmd_reg == rle_pkg::CMD_REMOVE) count_next = k_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    raddr = a_reg[AW-1:0];
                    state_next = S_SCHK;
                end
            end
            S_SCHK:
            begin
                // rdata holds entry a; a+1 is being fetched for next
                raddr = AW'(a_reg + 1'b1);
                state_next = S_SCAN;
                a_next = a_reg + 1'b1;
                case (cmd_reg)
                    rle_pkg::CMD_REMOVE:
                    begin
                        if (rdata_reg != val_reg)
                        begin
                            we = 1'b1; waddr = k_reg[AW-1:0]; wdata = rdata_reg;
                            k_next = k_reg + 1'b1;
                        end
                    end
                    rle_pkg::CMD_MEMBER:
                    begin
                        if (rdata_reg == val_reg)
                        begin
                            fnd_next = 1'b1;
                            state_next = S_DONE;
                        end
                    end
                    default:
                    begin
                        // next: remember hit, take following entry on next pass
                        if (da_reg[0])
                            res_next = rdata_reg;
                        da_next = '0;
                        if (rdata_reg == val_reg && (a_reg + 1'b1) < count_reg)
                        begin
                            fnd_next = 1'b1;
                            da_next = VALUE_WIDTH'(1);
                        end
                    end
                endcase
            end
            S_RA:
            begin
                raddr = a_reg[AW-1:0];
                state_next = S_RB;
            end
            S_RB:
            begin
                raddr = b_reg[AW-1:0];
                da_next = rdata_reg;
                state_next = S_RC;
            end
            S_RC:
            begin
                state_next = S_DONE;
                if (cmd_reg == rle_pkg::CMD_SWAP)
                begin
                    we = 1'b1; waddr = a_reg[AW-1:0]; wdata = rdata_reg;
                    state_next = S_WB;
                end
                else if (a_reg < b_reg)
                begin
                    if (cmd_reg == rle_pkg::CMD_REV_DEP && da_reg == depot_reg)
                    begin
                        a_next = a_reg + 1'b1;
                        state_next = S_RA;
                    end
                    else if (cmd_reg == rle_pkg::CMD_REV_DEP && rdata_reg == depot_reg)
                    begin
                        b_next = b_reg - 1'b1;
                        state_next = S_RA;
                    end
                    else
                    begin
                        we = 1'b1; waddr = a_reg[AW-1:0]; wdata = rdata_reg;
                        state_next = S_WB;
                    end
                end
            end
            S_WB:
            begin
                we = 1'b1; waddr = b_reg[AW-1:0]; wdata = da_reg;
                if (cmd_reg == rle_pkg::CMD_SWAP)
                    state_next = S_DONE;
                else
                begin
                    a_next = a_reg + 1'b1;
                    b_next = b_reg - 1'b1;
                    state_next = S_RA;
                end
            end
            S_DONE:
            begin
                done_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            cmd_reg <= command;
            val_reg <= value;
        end
        a_reg <= a_next; b_reg <= b_next; k_reg <= k_next;
        da_reg <= (state_reg == S_IDLE) ? '0 : da_next;
        res_reg <= res_next; fnd_reg <= fnd_next; ovf_reg <= ovf_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign result_value = res_reg;
    assign found        = fnd_reg;
    assign overflow     = ovf_reg;
    assign item_count   = count_reg;
    assign is_full      = (count_reg >= lim);
    assign list_empty   = (count_reg == '0);

    `RLE_ASSERT_IMPL(a_cnt_bound, 1'b1, 32'(count_reg) <= DEPTH, "count above depth")
    `RLE_ASSERT_IMPL(a_done_idle, done, !busy, "done while busy")
    `RLE_ASSERT_IMPL(a_ovf_done, done && overflow, is_full, "overflow while not full")
    `RLE_ASSERT_NEXT(a_start_busy, start && !busy, busy, "start not taken")
endmodule
`default_nettype wire

FILE: tb/tb_route_list_engine.sv
// ---------------------------------------------------------------------------
// tb_route_list_engine
// Self-checking bench for the route list engine.
// ---------------------------------------------------------------------------
// Commands go in through the start/busy handshake, with random gaps between
// them. At each accepted command the bench updates its own copy of the list
// and queues the result that the command should give. Every done strobe is
// compared field by field against the oldest queued result. Capacity and
// depot registers are rewritten between phases while the engine is idle.
// ---------------------------------------------------------------------------
`default_nettype none
module tb_route_list_engine;
    import rle_pkg::*;

    localparam int LIST_DEPTH    = DEPTH_DEF;
    localparam int WATCHDOG_MAX  = 5000;
    localparam int SETTLE_CYCLES = 200;

    typedef struct packed {
        logic [15:0]      result_value;
        logic             found;
        logic [CNT_W-1:0] item_count;
        logic             is_full;
        logic             list_empty;
        logic             overflow;
    } route_status_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  done;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic [CMD_W-1:0]      command;
    logic [15:0]           value;
    logic [IDX_W-1:0]      first_index;
    logic [IDX_W-1:0]      second_index;
    logic [15:0]           result_value;
    logic                  found;
    logic [CNT_W-1:0]      item_count;
    logic                  is_full;
    logic                  list_empty;
    logic                  overflow;

    // shadow copy of the list and registers
    logic [15:0]   node_list [LIST_DEPTH];
    int            node_count;
    int            cap_reg;
    logic [15:0]   depot_reg;
    route_status_t status_queue [$];

    int fail_count;
    int sent_count;
    int checked_count;
    int idle_cycles;

    route_list_engine i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .done         (done),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .command      (command),
        .value        (value),
        .first_index  (first_index),
        .second_index (second_index),
        .result_value (result_value),
        .found        (found),
        .item_count   (item_count),
        .is_full      (is_full),
        .list_empty   (list_empty),
        .overflow     (overflow)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // compute the status of one command and update the shadow list
    function automatic route_status_t route_apply(logic [CMD_W-1:0] cmd, logic [15:0] val,
                                                  int lo, int hi);
        route_status_t st;
        int            lim;
        int            kept;
        int            a;
        int            b;
        logic [15:0]   tmp;
        st  = '0;
        lim = (cap_reg < LIST_DEPTH) ? cap_reg : LIST_DEPTH;
        case (cmd)
            CMD_CLEAR:
            begin
                node_count = 0;
            end
            CMD_APPEND:
            begin
                if (node_count >= lim)
                    st.overflow = 1'b1;
                else
                begin
                    node_list[node_count] = val;
                    node_count++;
                end
            end
            CMD_REMOVE:
            begin
                kept = 0;
                for (int i = 0; i < node_count; i++)
                begin
                    if (node_list[i] != val)
                    begin
                        node_list[kept] = node_list[i];
                        kept++;
                    end
                end
                node_count = kept;
            end
            CMD_REVERSE, CMD_REV_DEP:
            begin
                if (lo <= hi && hi < node_count)
                begin
                    a = lo;
                    b = hi;
                    while (a < b)
                    begin
                        if (cmd == CMD_REV_DEP && node_list[a] == depot_reg)
                            a++;
                        else if (cmd == CMD_REV_DEP && node_list[b] == depot_reg)
                            b--;
                        else
                        begin
                            tmp          = node_list[a];
                            node_list[a] = node_list[b];
                            node_list[b] = tmp;
                            a++;
                            b--;
                        end
                    end
                end
            end
            CMD_SWAP:
            begin
                if (lo < node_count && hi < node_count)
                begin
                    tmp           = node_list[lo];
                    node_list[lo] = node_list[hi];
                    node_list[hi] = tmp;
                end
            end
            CMD_MEMBER:
            begin
                for (int i = 0; i < node_count; i++)
                    if (node_list[i] == val)
                        st.found = 1'b1;
            end
            CMD_NEXT:
            begin
                for (int i = 0; i + 1 < node_count; i++)
                begin
                    if (node_list[i] == val)
                    begin
                        st.found        = 1'b1;
                        st.result_value = node_list[i + 1];
                    end
                end
            end
            CMD_READ:
            begin
                if (lo < node_count)
                    st.result_value = node_list[lo];
            end
            default:
            begin
            end
        endcase
        st.item_count = node_count[CNT_W-1:0];
        st.is_full    = (node_count >= lim);
        st.list_empty = (node_count == 0);
        return st;
    endfunction

    // send one item after a random gap and queue its expected status;
    // start stays high after acceptance so a zero gap follows at once
    task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [15:0] val, int lo, int hi);
        int gap;
        gap = $urandom_range(0, 5);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        command      <= cmd;
        value        <= val;
        first_index  <= lo[IDX_W-1:0];
        second_index <= hi[IDX_W-1:0];
        @(posedge clk);
        while (busy)
            @(posedge clk);
        status_queue.push_back(route_apply(cmd, val, lo, hi));
        sent_count++;
    endtask

    // drop start and hold until every queued status has come back
    task automatic wait_drained();
        start <= 1'b0;
        while (status_queue.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write one register while the engine is idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_CAPACITY)
            cap_reg = data & 'h7F;
        else
            depot_reg = data[15:0];
        @(posedge clk);
    endtask

    // check each result against the oldest expectation
    always @(posedge clk)
    begin
        route_status_t exp_st;
        if (rst_n && done)
        begin
            if (status_queue.size() == 0)
            begin
                $error("result with no command outstanding");
                fail_count++;
            end
            else
            begin
                exp_st = status_queue.pop_front();
                checked_count++;
                if (result_value !== exp_st.result_value)
                begin
                    $error("result_value exp %0h got %0h", exp_st.result_value, result_value);
                    fail_count++;
                end
                if (found !== exp_st.found)
                begin
                    $error("found exp %0b got %0b", exp_st.found, found);
                    fail_count++;
                end
                if (item_count !== exp_st.item_count)
                begin
                    $error("item_count exp %0d got %0d", exp_st.item_count, item_count);
                    fail_count++;
                end
                if (is_full !== exp_st.is_full)
                begin
                    $error("is_full exp %0b got %0b", exp_st.is_full, is_full);
                    fail_count++;
                end
                if (list_empty !== exp_st.list_empty)
                begin
                    $error("list_empty exp %0b got %0b", exp_st.list_empty, list_empty);
                    fail_count++;
                end
                if (overflow !== exp_st.overflow)
                begin
                    $error("overflow exp %0b got %0b", exp_st.overflow, overflow);
                    fail_count++;
                end
            end
        end
    end

    // end the run when nothing is accepted for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_MAX)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic test_basic_ops();
        send_cmd(CMD_READ, 16'h0000, 0, 0);
        send_cmd(CMD_APPEND, 16'hFFFF, 0, 0);
        send_cmd(CMD_APPEND, 16'h0000, 0, 0);
        send_cmd(CMD_APPEND, 16'h1234, 0, 0);
        send_cmd(CMD_APPEND, 16'hFFFF, 0, 0);
        send_cmd(CMD_APPEND, 16'h00AA, 0, 0);
        send_cmd(CMD_READ, 16'h0000, 63, 0);
        send_cmd(CMD_READ, 16'h0000, 4, 0);
        send_cmd(CMD_MEMBER, 16'h1234, 0, 0);
        send_cmd(CMD_MEMBER, 16'h4321, 0, 0);
        send_cmd(CMD_NEXT, 16'hFFFF, 0, 0);
        send_cmd(CMD_NEXT, 16'h00AA, 0, 0);
        send_cmd(CMD_SWAP, 16'h0000, 0, 4);
        send_cmd(CMD_SWAP, 16'h0000, 0, 63);
        send_cmd(CMD_REVERSE, 16'h0000, 0, 4);
        send_cmd(CMD_REVERSE, 16'h0000, 3, 1);
        send_cmd(CMD_REVERSE, 16'h0000, 0, 5);
        send_cmd(CMD_REV_DEP, 16'h0000, 0, 4);
        send_cmd(CMD_REMOVE, 16'hFFFF, 0, 0);
        send_cmd(4'd9, 16'h0000, 0, 0);
        send_cmd(4'd15, 16'hFFFF, 63, 63);
        send_cmd(CMD_CLEAR, 16'h0000, 0, 0);
    endtask

    task automatic test_capacity_limits();
        write_reg(REG_CAPACITY, 1);
        send_cmd(CMD_APPEND, 16'h0005, 0, 0);
        send_cmd(CMD_APPEND, 16'h0006, 0, 0);
        write_reg(REG_CAPACITY, 0);
        send_cmd(CMD_APPEND, 16'h0007, 0, 0);
        send_cmd(CMD_CLEAR, 16'h0000, 0, 0);
        send_cmd(CMD_APPEND, 16'h0007, 0, 0);
        write_reg(REG_CAPACITY, 127);
        for (int i = 0; i < 66; i++)
            send_cmd(CMD_APPEND, 16'(i), 0, 0);
        send_cmd(CMD_REVERSE, 16'h0000, 0, 63);
        send_cmd(CMD_READ, 16'h0000, 63, 0);
        write_reg(REG_CAPACITY, 8);
        send_cmd(CMD_READ, 16'h0000, 10, 0);
        send_cmd(CMD_CLEAR, 16'h0000, 0, 0);
    endtask

    task automatic test_depot_reversal();
        write_reg(REG_CAPACITY, 64);
        write_reg(REG_DEPOT, 16'hFFFF);
        send_cmd(CMD_APPEND, 16'hFFFF, 0, 0);
        send_cmd(CMD_APPEND, 16'h0001, 0, 0);
        send_cmd(CMD_APPEND, 16'hFFFF, 0, 0);
        send_cmd(CMD_APPEND, 16'h0002, 0, 0);
        send_cmd(CMD_APPEND, 16'h0003, 0, 0);
        send_cmd(CMD_APPEND, 16'hFFFF, 0, 0);
        send_cmd(CMD_REV_DEP, 16'h0000, 0, 5);
        send_cmd(CMD_REV_DEP, 16'h0000, 1, 4);
        for (int i = 0; i < 6; i++)
            send_cmd(CMD_READ, 16'h0000, i, 0);
        send_cmd(CMD_REMOVE, 16'hFFFF, 0, 0);
        send_cmd(CMD_CLEAR, 16'h0000, 0, 0);
    endtask

    // random phases of list building and editing under varied registers
    task automatic test_random_routes();
        int          caps [7] = '{1, 2, 5, 16, 64, 127, 0};
        int          pick;
        int          lo;
        int          hi;
        logic [15:0] val;
        logic [CMD_W-1:0] cmd;
        for (int ph = 0; ph < 7; ph++)
        begin
            write_reg(REG_CAPACITY, caps[ph]);
            write_reg(REG_DEPOT, ($urandom_range(0, 1) != 0) ? $urandom_range(0, 7)
                                                             : $urandom_range(0, 65535));
            for (int n = 0; n < 210; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 35)      cmd = CMD_APPEND;
                else if (pick < 42) cmd = CMD_REMOVE;
                else if (pick < 52) cmd = CMD_REVERSE;
                else if (pick < 62) cmd = CMD_REV_DEP;
                else if (pick < 70) cmd = CMD_SWAP;
                else if (pick < 78) cmd = CMD_MEMBER;
                else if (pick < 86) cmd = CMD_NEXT;
                else if (pick < 95) cmd = CMD_READ;
                else if (pick < 97) cmd = CMD_CLEAR;
                else                cmd = 4'($urandom_range(9, 15));
                pick = $urandom_range(0, 3);
                if (pick == 0)      val = 16'($urandom_range(0, 65535));
                else if (pick == 1) val = depot_reg;
                else                val = 16'($urandom_range(0, 7));
                if (node_count > 0 && $urandom_range(0, 9) < 8)
                begin
                    lo = $urandom_range(0, node_count - 1);
                    hi = $urandom_range(0, node_count - 1);
                    if (cmd != CMD_SWAP && lo > hi && $urandom_range(0, 3) != 0)
                    begin
                        pick = lo;
                        lo   = hi;
                        hi   = pick;
                    end
                end
                else
                begin
                    lo = $urandom_range(0, 63);
                    hi = $urandom_range(0, 63);
                end
                send_cmd(cmd, val, lo, hi);
                // let the pipeline empty now and then
                if ($urandom_range(0, 99) == 0)
                    wait_drained();
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        command       = '0;
        value         = '0;
        first_index   = '0;
        second_index  = '0;
        node_count    = 0;
        cap_reg       = 64;
        depot_reg     = '0;
        fail_count    = 0;
        sent_count    = 0;
        checked_count = 0;
        idle_cycles   = 0;
        for (int i = 0; i < LIST_DEPTH; i++)
            node_list[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_ops();
        test_capacity_limits();
        test_depot_reversal();
        test_random_routes();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Covered %0d commands (all codes, capacities 0..127, depot moves), %0d results",
                 sent_count, checked_count);
        if (fail_count == 0 && status_queue.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire
